FILE: sv/sil_pkg.sv
// Shared types, widths and codes for the stable sorted insertion list.
package sil_pkg;

  localparam int CAPACITY = 256;
  // Wide enough to hold the count itself, which reaches CAPACITY.
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int POS_W    = 9;
  localparam int TAG_W    = 16;
  localparam int SCORE_W  = 16;
  localparam int REGION_W = 8;
  localparam int INDEX_W  = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int OP_W     = 3;

  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // What a word still has to do as it travels along the row of cells.
  localparam logic [OP_W-1:0] OP_PASS   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_SHIFT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [SCORE_W-1:0]  score;
    logic [REGION_W-1:0] region;
  } entry_t;

  typedef struct packed {
    logic [POS_W-1:0]    position;
    entry_t              ent;
    logic [POS_W-1:0]    count;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CW-1:0]      left;
    logic [CW-1:0]      pos;
    logic [INDEX_W-1:0] index;
    entry_t             carry;
    result_t            res;
  } wave_t;

endpackage

FILE: sv/stable_sorted_insert_list.sv
// Top level of the stable sorted insertion list: front stage, row of cells and output register.
// Entries sit in a row of CAPACITY cells; inserts keep falling score order and appends go
// to the tail. Each input word becomes a wave that moves one cell per clock along the whole row;
// the cell it reaches compares, stores, shifts or reads its slot, so a word enters every cycle
// and its result leaves through the front stage, CAPACITY cells and output register, in input
// order. An output stall freezes the whole row, and in_stall follows it directly.
module stable_sorted_insert_list import sil_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [TAG_W-1:0]    tag,
  input  logic [SCORE_W-1:0]  score,
  input  logic [REGION_W-1:0] region,
  input  logic [INDEX_W-1:0]  index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [POS_W-1:0]    position,
  output logic [TAG_W-1:0]    out_tag,
  output logic [SCORE_W-1:0]  out_score,
  output logic [REGION_W-1:0] out_region,
  output logic [POS_W-1:0]    count,
  output logic [STATUS_W-1:0] status
);

  logic    advance;
  logic    act [CAPACITY+1];
  wave_t   wv  [CAPACITY+1];
  result_t res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  sil_issue u_issue (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .take     (in_valid),
    .kind     (kind),
    .tag      (tag),
    .score    (score),
    .region   (region),
    .index    (index),
    .w_active (act[0]),
    .w_out    (wv[0])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    sil_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .in_active  (act[i]),
      .w_in       (wv[i]),
      .out_active (act[i+1]),
      .w_out      (wv[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= act[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (advance && act[CAPACITY]) begin
      res <= wv[CAPACITY].res;
    end
  end

  assign position   = res.position;
  assign out_tag    = res.ent.tag;
  assign out_score  = res.ent.score;
  assign out_region = res.ent.region;
  assign count      = res.count;
  assign status     = res.status;

  // A refused word is only ever reported against a full list.
  a_full_count : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (count == POS_W'(CAPACITY)))
    else $error("full refusal reported with a list that is not full");

  // A read flagged out of range really lies at or beyond the count.
  a_range_pos : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_RANGE) |-> (position >= count))
    else $error("range error reported for an index below the count");

  // An OK result with a nonzero region, placed entry or read, lies inside the list it reports.
  a_place_inside : assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && count != '0 && out_region != '0) |->
      (position < count))
    else $error("result position lies beyond the entry count");

  // While the output is stalled the row holds, so no new word may enter.
  a_hold_input : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("input taken while the row is frozen");

endmodule

FILE: sv/sil_issue.sv
// Front stage: keeps the entry count and turns each input word into a wave for the cells.
module sil_issue import sil_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                take,
  input  logic [KIND_W-1:0]   kind,
  input  logic [TAG_W-1:0]    tag,
  input  logic [SCORE_W-1:0]  score,
  input  logic [REGION_W-1:0] region,
  input  logic [INDEX_W-1:0]  index,
  output logic                w_active,
  output wave_t               w_out
);

  logic [CW-1:0] entry_count;
  logic [CW-1:0] entry_count_next;
  wave_t         w_next;
  entry_t        offered;

  always_comb begin
    offered          = '{tag: tag, score: score, region: region};
    entry_count_next = entry_count;
    w_next           = '0;
    w_next.op        = OP_PASS;
    w_next.left      = entry_count;
    w_next.pos       = '0;
    w_next.index     = index;
    w_next.carry     = offered;
    w_next.res.count = POS_W'(entry_count);
    w_next.res.status = ST_OK;
    case (kind)
      KIND_CLEAR: begin
        entry_count_next = '0;
        w_next.res.count = '0;
      end
      KIND_READ: begin
        w_next.res.position = POS_W'(index);
        if (16'(index) >= 16'(entry_count)) begin
          w_next.res.status = ST_RANGE;
        end else begin
          w_next.op = OP_READ;
        end
      end
      KIND_APPEND, KIND_INSERT: begin
        w_next.res.ent = offered;
        if (entry_count == CW'(CAPACITY)) begin
          w_next.res.status = ST_FULL;
        end else begin
          w_next.op        = (kind == KIND_INSERT) ? OP_INSERT : OP_APPEND;
          entry_count_next = entry_count + CW'(1);
          w_next.res.count = POS_W'(entry_count + CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      w_active    <= 1'b0;
    end else if (advance) begin
      w_active <= take;
      if (take) begin
        entry_count <= entry_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      w_out <= w_next;
    end
  end

endmodule

FILE: sv/sil_cell.sv
// One list slot: holds an entry and acts on the wave passing through it.
module sil_cell import sil_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  logic  in_active,
  input  wave_t w_in,
  output logic  out_active,
  output wave_t w_out
);

  entry_t slot;
  entry_t slot_next;
  wave_t  w_next;
  logic   at_tail;

  always_comb begin
    // No valid entries lie at or beyond this slot when left is zero.
    at_tail   = (w_in.left == '0);
    slot_next = slot;
    w_next    = w_in;
    w_next.pos  = w_in.pos + CW'(1);
    w_next.left = at_tail ? '0 : w_in.left - CW'(1);
    case (w_in.op)
      OP_APPEND: begin
        if (at_tail) begin
          slot_next           = w_in.carry;
          w_next.op           = OP_PASS;
          w_next.res.position = POS_W'(w_in.pos);
        end
      end
      OP_INSERT: begin
        if (at_tail) begin
          slot_next           = w_in.carry;
          w_next.op           = OP_PASS;
          w_next.res.position = POS_W'(w_in.pos);
        end else if (w_in.carry.score > slot.score) begin
          // The new entry goes here and the old one is pushed down the row.
          slot_next           = w_in.carry;
          w_next.carry        = slot;
          w_next.op           = OP_SHIFT;
          w_next.res.position = POS_W'(w_in.pos);
        end
      end
      OP_SHIFT: begin
        slot_next    = w_in.carry;
        w_next.carry = slot;
        if (at_tail) begin
          w_next.op = OP_PASS;
        end
      end
      OP_READ: begin
        if (w_in.pos == CW'(w_in.index)) begin
          w_next.res.ent = slot;
          w_next.op      = OP_PASS;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_active <= 1'b0;
    end else if (advance) begin
      out_active <= in_active;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_active) begin
      slot  <= slot_next;
      w_out <= w_next;
    end
  end

endmodule
